// ===== rtl/core/dors_pkg.sv =====
// Shared types and codes for the diagonal-or-rotate command selector.
package dors_pkg;

	typedef enum logic [1:0] {
		SEL_INIT = 2'd0,
		SEL_DIAG = 2'd1,
		SEL_ROT  = 2'd2,
		SEL_FREE = 2'd3
	} sel_state_t;

	localparam logic [1:0] MODE_POS_FLEX = 2'd1;
	localparam logic [1:0] MODE_INF_FLEX = 2'd2;

	localparam logic [1:0] LOAD_NONE      = 2'd0;
	localparam logic [1:0] LOAD_SINGLE    = 2'd1;
	localparam logic [1:0] LOAD_COMPOSITE = 2'd2;

	localparam logic [1:0] CFG_SELECT_ENABLE   = 2'd0;
	localparam logic [1:0] CFG_FORCE_EXCLUSIVE = 2'd1;
	localparam logic [1:0] CFG_LIFT_POLARITY   = 2'd2;

	typedef struct packed {
		logic select_enable;
		logic force_exclusive;
		logic lift_press_polarity;
	} cfg_t;

	typedef struct packed {
		sel_state_t state;
		logic       free_flag;
		logic       free_last;
		logic       axis;
	} sel_ctx_t;

endpackage

// ===== rtl/core/dors_step.sv =====
// Per-command selection logic: mode decision, selector transition and velocity gating.
module dors_step #(
	parameter int VEL_WIDTH = 16
) (
	input  dors_pkg::cfg_t              cfg,
	input  dors_pkg::sel_ctx_t          ctx,
	input  logic [1:0]                  mode_class,
	input  logic                        linked_vehicle,
	input  logic                        lift_button,
	input  logic                        auto_center_button,
	input  logic signed [VEL_WIDTH-1:0] vel_x_in,
	input  logic signed [VEL_WIDTH-1:0] vel_y_in,
	input  logic signed [VEL_WIDTH-1:0] vel_z_in,
	output dors_pkg::sel_ctx_t          ctx_next,
	output logic signed [VEL_WIDTH-1:0] vel_x_out,
	output logic signed [VEL_WIDTH-1:0] vel_y_out,
	output logic signed [VEL_WIDTH-1:0] vel_z_out,
	output logic                        clear_smoothing,
	output logic [1:0]                  param_load
);
	import dors_pkg::*;

	logic                 flex;
	logic                 excl;
	logic                 ff;
	logic                 all_zero;
	logic                 change;
	logic                 diag_nz;
	logic                 vz_nz;
	sel_state_t           st;

	always_comb begin
		flex     = (mode_class == MODE_POS_FLEX) || (mode_class == MODE_INF_FLEX);
		excl     = (cfg.select_enable && flex && (lift_button == cfg.lift_press_polarity)
			&& !auto_center_button) || cfg.force_exclusive;
		ff       = !excl;
		vz_nz    = (vel_z_in != '0);
		all_zero = (vel_x_in == '0) && (vel_y_in == '0) && !vz_nz;
		change   = (ff != ctx.free_last) && all_zero;
		if (mode_class == MODE_POS_FLEX) begin
			diag_nz = (vel_x_in != '0);
		end else if (mode_class == MODE_INF_FLEX) begin
			diag_nz = (vel_y_in != '0);
		end else begin
			diag_nz = 1'b0;
		end

		ctx_next        = ctx;
		vel_x_out       = vel_x_in;
		vel_y_out       = vel_y_in;
		vel_z_out       = vel_z_in;
		clear_smoothing = 1'b0;
		param_load      = LOAD_NONE;
		st              = ctx.state;

		if (!linked_vehicle) begin
			ctx_next.free_flag = ff;
			if (change) begin
				st                 = SEL_INIT;
				ctx_next.free_last = ff;
				clear_smoothing    = 1'b1;
			end
			if (mode_class == MODE_POS_FLEX) begin
				ctx_next.axis = 1'b0;
			end else if (mode_class == MODE_INF_FLEX) begin
				ctx_next.axis = 1'b1;
			end
			ctx_next.state = st;
			case (st)
				SEL_INIT: begin
					if (!ff) begin
						if (diag_nz) begin
							ctx_next.state = SEL_DIAG;
						end else if (vz_nz) begin
							ctx_next.state = SEL_ROT;
						end
						param_load = LOAD_SINGLE;
					end else begin
						ctx_next.state = SEL_FREE;
						param_load     = LOAD_COMPOSITE;
					end
				end
				SEL_DIAG: begin
					if (!diag_nz) begin
						ctx_next.state = SEL_INIT;
					end else begin
						vel_z_out = '0;
					end
				end
				SEL_ROT: begin
					if (!vz_nz) begin
						ctx_next.state = SEL_INIT;
					end else if (mode_class == MODE_POS_FLEX) begin
						vel_x_out = '0;
					end else if (mode_class == MODE_INF_FLEX) begin
						vel_y_out = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/diagonal_or_rotate_command_selector_top.sv =====
// Diagonal-or-rotate command selector: input register, selection logic, result register.
// A command accepted into the input register passes through the selection logic into the
// result register, which presents it on the result side.
// Throughput: one command per cycle; the input register advances when the result register
// is empty or being taken; a waiting result stalls intake once the input register is full.
// Reset: arst_n clears the configuration, the selector state and the valid flags.
module diagonal_or_rotate_command_selector_top #(
	parameter int VEL_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic                        cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode_class,
	input  logic                        linked_vehicle,
	input  logic                        lift_button,
	input  logic                        auto_center_button,
	input  logic signed [VEL_WIDTH-1:0] vel_x_in,
	input  logic signed [VEL_WIDTH-1:0] vel_y_in,
	input  logic signed [VEL_WIDTH-1:0] vel_z_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [VEL_WIDTH-1:0] vel_x_out,
	output logic signed [VEL_WIDTH-1:0] vel_y_out,
	output logic signed [VEL_WIDTH-1:0] vel_z_out,
	output logic                        clear_smoothing,
	output logic [1:0]                  param_load,
	output logic                        diagonal_axis,
	output logic                        free_motion
);
	import dors_pkg::*;

	cfg_t                  cfg_q;
	sel_ctx_t              ctx_q;
	sel_ctx_t              ctx_nx;

	logic                  valid_s1;
	logic [1:0]            mode_s1;
	logic                  linked_s1;
	logic                  lift_s1;
	logic                  autoc_s1;
	logic signed [VEL_WIDTH-1:0] vx_s1;
	logic signed [VEL_WIDTH-1:0] vy_s1;
	logic signed [VEL_WIDTH-1:0] vz_s1;

	logic signed [VEL_WIDTH-1:0] vx_c;
	logic signed [VEL_WIDTH-1:0] vy_c;
	logic signed [VEL_WIDTH-1:0] vz_c;
	logic                  clr_c;
	logic [1:0]            load_c;

	logic                  valid_s2;
	logic                  advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SELECT_ENABLE:   cfg_q.select_enable       <= cfg_data;
				CFG_FORCE_EXCLUSIVE: cfg_q.force_exclusive     <= cfg_data;
				CFG_LIFT_POLARITY:   cfg_q.lift_press_polarity <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode_class;
			linked_s1 <= linked_vehicle;
			lift_s1   <= lift_button;
			autoc_s1  <= auto_center_button;
			vx_s1     <= vel_x_in;
			vy_s1     <= vel_y_in;
			vz_s1     <= vel_z_in;
		end
	end

	dors_step #(
		.VEL_WIDTH(VEL_WIDTH)
	) u_step (
		.cfg                (cfg_q),
		.ctx                (ctx_q),
		.mode_class         (mode_s1),
		.linked_vehicle     (linked_s1),
		.lift_button        (lift_s1),
		.auto_center_button (autoc_s1),
		.vel_x_in           (vx_s1),
		.vel_y_in           (vy_s1),
		.vel_z_in           (vz_s1),
		.ctx_next           (ctx_nx),
		.vel_x_out          (vx_c),
		.vel_y_out          (vy_c),
		.vel_z_out          (vz_c),
		.clear_smoothing    (clr_c),
		.param_load         (load_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q    <= '{state: SEL_INIT, free_flag: 1'b0, free_last: 1'b0, axis: 1'b0};
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				ctx_q    <= ctx_nx;
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vel_x_out       <= vx_c;
			vel_y_out       <= vy_c;
			vel_z_out       <= vz_c;
			clear_smoothing <= clr_c;
			param_load      <= load_c;
			diagonal_axis   <= ctx_nx.axis;
			free_motion     <= ctx_nx.free_flag;
		end
	end

endmodule
